// File: sv/wall_follow_pid_steering_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the wall-following steering block
// Shared property wrappers clocked on i_clk, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef WALL_FOLLOW_PID_STEERING_ASSERT_SVH
`define WALL_FOLLOW_PID_STEERING_ASSERT_SVH

// Checked only while the block is out of reset.
`define WFPS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define WFPS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: sv/wfps_pkg.sv
// ----------------------------------------------------------------------------
// wfps_pkg
// Types and constants shared by the wall-following steering modules.
// ----------------------------------------------------------------------------
`default_nettype none

package wfps_pkg;

    localparam int DIST_W     = 12;
    localparam int GAIN_W     = 16;
    localparam int SPEED_W    = 8;
    localparam int CASE_W     = 2;
    localparam int ERR_W      = 9;
    localparam int SUM_W      = 10;
    localparam int DIFF_W     = 10;
    localparam int PROD_W     = 27;
    localparam int CORR_W     = 28;
    localparam int FRAC_SHIFT = 12;
    localparam int Q_W        = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_WALL_THRESH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_DIST  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P       = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I       = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D       = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FRONT_MIN    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CRUISE_LEVEL = 4'd7;

    localparam logic [CASE_W-1:0] CASE_CORRIDOR = 2'd0;
    localparam logic [CASE_W-1:0] CASE_LEFT     = 2'd1;
    localparam logic [CASE_W-1:0] CASE_RIGHT    = 2'd2;
    localparam logic [CASE_W-1:0] CASE_OPEN     = 2'd3;

    localparam logic signed [DIST_W:0]  ERR_LIMIT  = 13'sd128;
    localparam logic signed [SUM_W:0]   SUM_LIMIT  = 11'sd320;
    localparam logic [DIST_W-1:0]       FRONT_NEAR = 12'd400;
    localparam logic signed [CORR_W-1:0] BIAS_CORR = 28'sd20480;

    typedef struct packed {
        logic [DIST_W-1:0]  wall_thresh;
        logic [DIST_W-1:0]  target_dist;
        logic [DIST_W-1:0]  deadband;
        logic [GAIN_W-1:0]  gain_p;
        logic [GAIN_W-1:0]  gain_i;
        logic [GAIN_W-1:0]  gain_d;
        logic [DIST_W-1:0]  front_min;
        logic [SPEED_W-1:0] cruise_level;
    } t_cfg;

    typedef struct packed {
        logic signed [ERR_W-1:0] err;
        logic [CASE_W-1:0]       wall_case;
    } t_err_res;

endpackage

`default_nettype wire

// File: sv/wfps_err_calc.sv
// ----------------------------------------------------------------------------
// wfps_err_calc
// Classifies the walls seen and forms the clamped steering error.
// ----------------------------------------------------------------------------
`default_nettype none

module wfps_err_calc
    import wfps_pkg::*;
(
    input  wire logic [DIST_W-1:0] i_left_diag,
    input  wire logic [DIST_W-1:0] i_right_diag,
    input  wire t_cfg              i_cfg,
    output t_err_res               o_res
);

    logic                     left_wall;
    logic                     right_wall;
    logic signed [DIST_W:0]   raw_err;
    logic signed [DIST_W:0]   db_err;
    logic [DIST_W:0]          mag;
    logic signed [DIST_W:0]   l_s;
    logic signed [DIST_W:0]   r_s;
    logic signed [DIST_W:0]   des_s;

    assign left_wall  = i_left_diag < i_cfg.wall_thresh;
    assign right_wall = i_right_diag < i_cfg.wall_thresh;
    assign l_s        = $signed({1'b0, i_left_diag});
    assign r_s        = $signed({1'b0, i_right_diag});
    assign des_s      = $signed({1'b0, i_cfg.target_dist});

    always_comb begin
        if (left_wall && right_wall) begin
            raw_err         = l_s - r_s;
            o_res.wall_case = CASE_CORRIDOR;
        end else if (left_wall) begin
            raw_err         = des_s - l_s;
            o_res.wall_case = CASE_LEFT;
        end else if (right_wall) begin
            raw_err         = r_s - des_s;
            o_res.wall_case = CASE_RIGHT;
        end else begin
            raw_err         = '0;
            o_res.wall_case = CASE_OPEN;
        end

        mag    = raw_err[DIST_W] ? unsigned'(-raw_err) : unsigned'(raw_err);
        db_err = (mag < {1'b0, i_cfg.deadband}) ? '0 : raw_err;

        if (db_err > ERR_LIMIT) begin
            o_res.err = ERR_LIMIT[ERR_W-1:0];
        end else if (db_err < -ERR_LIMIT) begin
            o_res.err = ERR_W'(-ERR_LIMIT);
        end else begin
            o_res.err = db_err[ERR_W-1:0];
        end
    end

endmodule

`default_nettype wire

// File: sv/wfps_mix.sv
// ----------------------------------------------------------------------------
// wfps_mix
// Truncates a scaled motor level toward zero and saturates it.
// ----------------------------------------------------------------------------
`default_nettype none

module wfps_mix
    import wfps_pkg::*;
#(
    parameter int SPEED_MIN = 0,
    parameter int SPEED_MAX = 255
) (
    input  wire logic signed [CORR_W-1:0] i_scaled,
    output logic [SPEED_W-1:0]            o_speed
);

    localparam logic signed [Q_W-1:0] LIM_MIN = Q_W'(SPEED_MIN);
    localparam logic signed [Q_W-1:0] LIM_MAX = Q_W'(SPEED_MAX);
    localparam logic signed [CORR_W-1:0] ROUND_UP = CORR_W'((1 << FRAC_SHIFT) - 1);

    logic signed [CORR_W-1:0] adj;
    logic signed [Q_W-1:0]    q;

    always_comb begin
        adj = i_scaled[CORR_W-1] ? (i_scaled + ROUND_UP) : i_scaled;
        q   = $signed(adj[FRAC_SHIFT+Q_W-1:FRAC_SHIFT]);
        if (q < LIM_MIN) begin
            o_speed = LIM_MIN[SPEED_W-1:0];
        end else if (q > LIM_MAX) begin
            o_speed = LIM_MAX[SPEED_W-1:0];
        end else begin
            o_speed = q[SPEED_W-1:0];
        end
    end

endmodule

`default_nettype wire

// File: sv/wall_follow_pid_steering.sv
// ----------------------------------------------------------------------------
// wall_follow_pid_steering
// PID steering for a wall-following differential-drive robot.
// ----------------------------------------------------------------------------
// The block takes one transaction of three distance samples per clock while
// not stalled and returns one transaction of two motor levels and the wall
// case. The stages are the input register, the error stage (which also
// updates the integral and the previous error, so the controller state closes
// its loop within that stage), the three gain multipliers, and the correction
// sum with mixing and saturation in the output register. A stall on the output
// backs up stage by stage.
// ----------------------------------------------------------------------------
`default_nettype none

module wall_follow_pid_steering
    import wfps_pkg::*;
#(
    parameter int SPEED_MIN = 0,
    parameter int SPEED_MAX = 255
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [DIST_W-1:0]     i_left_diag,
    input  wire logic [DIST_W-1:0]     i_right_diag,
    input  wire logic [DIST_W-1:0]     i_front_dist,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [SPEED_W-1:0]         o_left_speed,
    output logic [SPEED_W-1:0]         o_right_speed,
    output logic [CASE_W-1:0]          o_wall_case
);

    t_cfg r_cfg;

    logic                     r_s0_valid;
    logic [DIST_W-1:0]        r_s0_left;
    logic [DIST_W-1:0]        r_s0_right;
    logic [DIST_W-1:0]        r_s0_front;

    logic                     r_s1_valid;
    logic signed [ERR_W-1:0]  r_s1_err;
    logic signed [SUM_W-1:0]  r_s1_sum;
    logic signed [DIFF_W-1:0] r_s1_diff;
    logic                     r_s1_bias_en;
    logic                     r_s1_bias_neg;
    logic [CASE_W-1:0]        r_s1_case;

    logic                     r_s2_valid;
    logic signed [PROD_W-1:0] r_s2_prod_p;
    logic signed [PROD_W-1:0] r_s2_prod_i;
    logic signed [PROD_W-1:0] r_s2_prod_d;
    logic                     r_s2_bias_en;
    logic                     r_s2_bias_neg;
    logic [CASE_W-1:0]        r_s2_case;

    logic                     r_s3_valid;
    logic [SPEED_W-1:0]       r_s3_left;
    logic [SPEED_W-1:0]       r_s3_right;
    logic [CASE_W-1:0]        r_s3_case;

    logic signed [ERR_W-1:0]  r_last_err;
    logic signed [SUM_W-1:0]  r_err_sum;

    logic                     ready0;
    logic                     ready1;
    logic                     ready2;
    logic                     ready3;

    t_err_res                 err_res;
    logic signed [SUM_W:0]    sum_raw;
    logic signed [SUM_W-1:0]  n_sum;
    logic signed [DIFF_W-1:0] n_diff;
    logic                     n_bias_en;
    logic                     n_bias_neg;

    logic signed [PROD_W-1:0] n_prod_p;
    logic signed [PROD_W-1:0] n_prod_i;
    logic signed [PROD_W-1:0] n_prod_d;

    logic signed [CORR_W-1:0] corr;
    logic signed [CORR_W-1:0] base_scaled;
    logic [SPEED_W-1:0]       n_left;
    logic [SPEED_W-1:0]       n_right;

    assign ready3  = !r_s3_valid || !i_stall;
    assign ready2  = !r_s2_valid || ready3;
    assign ready1  = !r_s1_valid || ready2;
    assign ready0  = !r_s0_valid || ready1;
    assign o_stall = !ready0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wall_thresh  <= 12'd480;
            r_cfg.target_dist  <= 12'd160;
            r_cfg.deadband     <= 12'd8;
            r_cfg.gain_p       <= 16'd512;
            r_cfg.gain_i       <= 16'd0;
            r_cfg.gain_d       <= 16'd256;
            r_cfg.front_min    <= 12'd160;
            r_cfg.cruise_level <= 8'd150;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_WALL_THRESH:  r_cfg.wall_thresh  <= i_cfg_data[DIST_W-1:0];
                REG_TARGET_DIST:  r_cfg.target_dist  <= i_cfg_data[DIST_W-1:0];
                REG_DEADBAND:     r_cfg.deadband     <= i_cfg_data[DIST_W-1:0];
                REG_GAIN_P:       r_cfg.gain_p       <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_I:       r_cfg.gain_i       <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_D:       r_cfg.gain_d       <= i_cfg_data[GAIN_W-1:0];
                REG_FRONT_MIN:    r_cfg.front_min    <= i_cfg_data[DIST_W-1:0];
                REG_CRUISE_LEVEL: r_cfg.cruise_level <= i_cfg_data[SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && ready0) begin
            r_s0_left  <= i_left_diag;
            r_s0_right <= i_right_diag;
            r_s0_front <= i_front_dist;
        end
    end

    wfps_err_calc u_err_calc (
        .i_left_diag  (r_s0_left),
        .i_right_diag (r_s0_right),
        .i_cfg        (r_cfg),
        .o_res        (err_res)
    );

    always_comb begin
        sum_raw = (SUM_W + 1)'(err_res.err) + (SUM_W + 1)'(r_err_sum);
        if (sum_raw > SUM_LIMIT) begin
            n_sum = SUM_LIMIT[SUM_W-1:0];
        end else if (sum_raw < -SUM_LIMIT) begin
            n_sum = SUM_W'(-SUM_LIMIT);
        end else begin
            n_sum = sum_raw[SUM_W-1:0];
        end
        n_diff     = DIFF_W'(err_res.err) - DIFF_W'(r_last_err);
        n_bias_en  = (r_s0_front < FRONT_NEAR) && (r_s0_front > r_cfg.front_min);
        n_bias_neg = r_s0_left > r_s0_right;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_err <= '0;
            r_err_sum  <= '0;
        end else if (r_s0_valid && ready1) begin
            r_last_err <= err_res.err;
            r_err_sum  <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s0_valid && ready1) begin
            r_s1_err      <= err_res.err;
            r_s1_sum      <= n_sum;
            r_s1_diff     <= n_diff;
            r_s1_bias_en  <= n_bias_en;
            r_s1_bias_neg <= n_bias_neg;
            r_s1_case     <= err_res.wall_case;
        end
    end

    always_comb begin
        n_prod_p = $signed(PROD_W'(r_cfg.gain_p)) * PROD_W'(r_s1_err);
        n_prod_i = $signed(PROD_W'(r_cfg.gain_i)) * PROD_W'(r_s1_sum);
        n_prod_d = $signed(PROD_W'(r_cfg.gain_d)) * PROD_W'(r_s1_diff);
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && ready2) begin
            r_s2_prod_p   <= n_prod_p;
            r_s2_prod_i   <= n_prod_i;
            r_s2_prod_d   <= n_prod_d;
            r_s2_bias_en  <= r_s1_bias_en;
            r_s2_bias_neg <= r_s1_bias_neg;
            r_s2_case     <= r_s1_case;
        end
    end

    always_comb begin
        corr = CORR_W'(r_s2_prod_p) + CORR_W'(r_s2_prod_i) + CORR_W'(r_s2_prod_d);
        if (r_s2_bias_en) begin
            corr = r_s2_bias_neg ? (corr - BIAS_CORR) : (corr + BIAS_CORR);
        end
        base_scaled = $signed(CORR_W'({r_cfg.cruise_level, {FRAC_SHIFT{1'b0}}}));
    end

    wfps_mix #(
        .SPEED_MIN (SPEED_MIN),
        .SPEED_MAX (SPEED_MAX)
    ) u_mix_left (
        .i_scaled (base_scaled - corr),
        .o_speed  (n_left)
    );

    wfps_mix #(
        .SPEED_MIN (SPEED_MIN),
        .SPEED_MAX (SPEED_MAX)
    ) u_mix_right (
        .i_scaled (base_scaled + corr),
        .o_speed  (n_right)
    );

    always_ff @(posedge i_clk) begin
        if (r_s2_valid && ready3) begin
            r_s3_left  <= n_left;
            r_s3_right <= n_right;
            r_s3_case  <= r_s2_case;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            if (ready0) begin
                r_s0_valid <= i_valid;
            end
            if (ready1) begin
                r_s1_valid <= r_s0_valid;
            end
            if (ready2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (ready3) begin
                r_s3_valid <= r_s2_valid;
            end
        end
    end

    assign o_valid       = r_s3_valid;
    assign o_left_speed  = r_s3_left;
    assign o_right_speed = r_s3_right;
    assign o_wall_case   = r_s3_case;

endmodule

`default_nettype wire

// File: sv/wfps_checker.sv
// ----------------------------------------------------------------------------
// wfps_checker
// Port-level assertions for the wall-following steering block.
// ----------------------------------------------------------------------------
`default_nettype none

`include "wall_follow_pid_steering_assert.svh"

module wfps_checker #(
    parameter int SPEED_MIN = 0,
    parameter int SPEED_MAX = 255
) (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic [7:0] o_left_speed,
    input wire logic [7:0] o_right_speed,
    input wire logic [1:0] o_wall_case
);

    localparam logic [7:0] LIM_LO = (SPEED_MIN < SPEED_MAX) ? 8'(SPEED_MIN) : 8'(SPEED_MAX);
    localparam logic [7:0] LIM_HI = (SPEED_MIN < SPEED_MAX) ? 8'(SPEED_MAX) : 8'(SPEED_MIN);

    logic [17:0] res_bits;
    logic        left_in_range;
    logic        right_in_range;

    assign res_bits       = {o_left_speed, o_right_speed, o_wall_case};
    assign left_in_range  = (o_left_speed >= LIM_LO) && (o_left_speed <= LIM_HI);
    assign right_in_range = (o_right_speed >= LIM_LO) && (o_right_speed <= LIM_HI);

    `WFPS_ASSERT_ALWAYS(a_reset_empties, !i_rst_n |=> !o_valid, "output valid after reset")
    `WFPS_ASSERT(a_valid_holds, o_valid && i_stall |=> o_valid, "stalled result dropped")
    `WFPS_ASSERT(a_payload_holds, o_valid && i_stall |=> $stable(res_bits), "payload not held")
    `WFPS_ASSERT(a_left_range, o_valid |-> left_in_range, "left speed out of range")
    `WFPS_ASSERT(a_right_range, o_valid |-> right_in_range, "right speed out of range")

endmodule

bind wall_follow_pid_steering wfps_checker #(
    .SPEED_MIN (SPEED_MIN),
    .SPEED_MAX (SPEED_MAX)
) u_wfps_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_left_speed  (o_left_speed),
    .o_right_speed (o_right_speed),
    .o_wall_case   (o_wall_case)
);

`default_nettype wire
